@@ sv/kmpq_pkg.sv @@
// Shared types and codes for the keyed minimum priority queue.
`timescale 1ns / 1ps

package kmpq_pkg;

    localparam int KEY_W  = 16;
    localparam int VAL_W  = 31;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [STAT_W-1:0] stat_t;

    localparam cmd_t CMD_ADD = 2'd0;
    localparam cmd_t CMD_DEQ = 2'd1;
    localparam cmd_t CMD_UPD = 2'd2;

    localparam stat_t ST_OK          = 3'd0;
    localparam stat_t ST_OVERWRITTEN = 3'd1;
    localparam stat_t ST_NOT_FOUND   = 3'd2;
    localparam stat_t ST_EMPTY       = 3'd3;
    localparam stat_t ST_FULL        = 3'd4;

    typedef struct packed {
        key_t key;
        val_t value;
    } entry_t;

    typedef struct packed {
        key_t  key;
        val_t  value;
        stat_t status;
        logic  now_empty;
    } result_t;

endpackage

@@ sv/kmpq_store.sv @@
// Entry memory: one write port and one registered read port.
`timescale 1ns / 1ps

module kmpq_store #(
    parameter int CAPACITY = 64
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  kmpq_pkg::entry_t            wr_data,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    output kmpq_pkg::entry_t            rd_data
);
    import kmpq_pkg::*;

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/kmpq_seq.sv @@
// Sequencer: key search, minimum search and compaction over the entry memory.
`timescale 1ns / 1ps

module kmpq_seq #(
    parameter int CAPACITY = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  kmpq_pkg::cmd_t              in_cmd,
    input  kmpq_pkg::key_t              in_key,
    input  kmpq_pkg::val_t              in_val,
    input  logic                        slot_free,
    output logic                        res_load,
    output kmpq_pkg::result_t           res,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output kmpq_pkg::entry_t            wr_data,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  kmpq_pkg::entry_t            rd_data
);
    import kmpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic        pend_reg, pend_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    cmd_t        cmd_reg, cmd_next;
    key_t        key_reg, key_next;
    val_t        val_reg, val_next;
    logic [AW-1:0] best_idx_reg, best_idx_next;
    key_t        best_key_reg, best_key_next;
    val_t        best_val_reg, best_val_next;
    key_t        res_key_reg, res_key_next;
    val_t        res_val_reg, res_val_next;
    stat_t       res_stat_reg, res_stat_next;

    logic issue;
    logic last;
    logic take;

    assign issue = (idx_reg < count_reg);
    assign last  = (CW'(cmp_idx_reg) == count_reg - CW'(1));
    // Strict less-than keeps the oldest of equal values.
    assign take  = (cmp_idx_reg == '0) || (rd_data.value < best_val_reg);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        best_val_next = best_val_reg;
        res_key_next  = res_key_reg;
        res_val_next  = res_val_reg;
        res_stat_next = res_stat_reg;
        in_ready      = 1'b0;
        res_load      = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = cmp_idx_reg;
        wr_data       = rd_data;
        rd_addr       = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd_next      = in_cmd;
                    key_next      = in_key;
                    val_next      = in_val;
                    res_key_next  = '0;
                    res_val_next  = '0;
                    res_stat_next = ST_OK;
                    idx_next      = '0;
                    state_next    = S_RESP;
                    if (in_cmd inside {CMD_ADD, CMD_DEQ, CMD_UPD}) begin
                        if (count_reg != '0) begin
                            state_next = S_SCAN;
                        end else if (in_cmd == CMD_ADD) begin
                            wr_en      = 1'b1;
                            wr_addr    = '0;
                            wr_data    = '{key: in_key, value: in_val};
                            count_next = CW'(1);
                        end else if (in_cmd == CMD_DEQ) begin
                            res_stat_next = ST_EMPTY;
                        end else begin
                            res_stat_next = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_SCAN: begin
                // Issue one read a cycle; check the one returned from the last cycle.
                if (issue) begin
                    idx_next     = idx_reg + CW'(1);
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                end
                if (pend_reg) begin
                    if (cmd_reg == CMD_DEQ) begin
                        if (take) begin
                            best_idx_next = cmp_idx_reg;
                            best_key_next = rd_data.key;
                            best_val_next = rd_data.value;
                        end
                        if (last) begin
                            res_key_next = take ? rd_data.key : best_key_reg;
                            res_val_next = take ? rd_data.value : best_val_reg;
                            idx_next     = CW'(take ? cmp_idx_reg : best_idx_reg) + CW'(1);
                            pend_next    = 1'b0;
                            state_next   = S_SHIFT;
                        end
                    end else if (rd_data.key == key_reg) begin
                        wr_en         = 1'b1;
                        wr_addr       = cmp_idx_reg;
                        wr_data       = '{key: rd_data.key, value: val_reg};
                        res_stat_next = ST_OVERWRITTEN;
                        pend_next     = 1'b0;
                        state_next    = S_RESP;
                    end else if (last) begin
                        pend_next  = 1'b0;
                        state_next = S_RESP;
                        if (cmd_reg == CMD_UPD) begin
                            res_stat_next = ST_NOT_FOUND;
                        end else if (count_reg == CW'(CAPACITY)) begin
                            res_stat_next = ST_FULL;
                        end else begin
                            wr_en      = 1'b1;
                            wr_addr    = count_reg[AW-1:0];
                            wr_data    = '{key: key_reg, value: val_reg};
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end
            S_SHIFT: begin
                // Move each entry after the removed one down by one place.
                if (issue) begin
                    idx_next     = idx_reg + CW'(1);
                    pend_next    = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                end
                if (pend_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = cmp_idx_reg - AW'(1);
                    wr_data = rd_data;
                end
                if (!issue && !pend_reg) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = '{key: res_key_reg, value: res_val_reg, status: res_stat_reg,
                   now_empty: (count_reg == '0)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        best_val_reg <= best_val_next;
        res_key_reg  <= res_key_next;
        res_val_reg  <= res_val_next;
        res_stat_reg <= res_stat_next;
    end

endmodule

@@ sv/keyed_min_priority_queue.sv @@
// Top level of the keyed minimum priority queue: sequencer, entry memory, result register.
//
//   Channel   Direction  Ports                                           Beat
//   s_        in         s_command, s_item_key, s_item_value            one command
//   m_        out        m_out_key, m_out_value, m_status, m_now_empty  one result per command
//
// Sequencing: add and update scan the held entries one per cycle, and a new beat is
// accepted only back in idle; dequeue scans for the minimum, then compacts the entries
// behind it one per cycle. The single memory read port sets this pace.
// Reset: aresetn, synchronous and active low, empties the queue; memory is not cleared.
// Stalls: the result register takes a finished result while the sequencer waits for the
// next beat; the sequencer holds a new result until that register is free.
`timescale 1ns / 1ps

module keyed_min_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  kmpq_pkg::cmd_t   s_command,
    input  kmpq_pkg::key_t   s_item_key,
    input  kmpq_pkg::val_t   s_item_value,
    output logic             m_valid,
    input  logic             m_ready,
    output kmpq_pkg::key_t   m_out_key,
    output kmpq_pkg::val_t   m_out_value,
    output kmpq_pkg::stat_t  m_status,
    output logic             m_now_empty
);
    import kmpq_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          res_load;
    result_t       res;
    logic          slot_free;

    logic          m_valid_reg, m_valid_next;
    result_t       m_res_reg;

    kmpq_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (s_command),
        .in_key    (s_item_key),
        .in_val    (s_item_value),
        .slot_free (slot_free),
        .res_load  (res_load),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    kmpq_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Free when empty or draining this cycle.
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the payload until a new result is loaded.
    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_res_reg <= res;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_key   = m_res_reg.key;
    assign m_out_value = m_res_reg.value;
    assign m_status    = m_res_reg.status;
    assign m_now_empty = m_res_reg.now_empty;

endmodule
